// File: sv/sulk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sulk_pkg
// Types and codes shared by the sorted unique key list and its cells.
// ----------------------------------------------------------------------------
package sulk_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // Request word
   typedef struct packed {
      logic              cmd;
      logic signed [KEY_W-1:0] key;
   } req_type;

   // Response word
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic compare_en;
      logic insert_en;
   } cell_ctl_type;

endpackage

// File: sv/sorted_unique_key_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_key_list
// Ascending list of distinct signed keys held in a row of compare-and-shift
// cells, with insert and search commands.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word             Handshake
//  req_      in         cmd, key         req_valid / req_ready
//  rsp_      out        status, pos, cnt rsp_valid / rsp_ready
//
//  Each word goes through accept, cell compare, then resolve and commit.
//  The resolve step encodes the cell flag row and shifts the cells in place.
//  A result waits in the output register; resolve holds while it is not taken.
//  A new word is accepted while a finished result still waits.
//  Reset clears the state, key count and result valid; cells need no clearing.
// ----------------------------------------------------------------------------
module sorted_unique_key_list #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sulk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sulk_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_RESOLVE = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic                              op_cmd_ff;
   logic signed [sulk_pkg::KEY_W-1:0] op_key_ff;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sulk_pkg::rsp_type                 rsp_data_ff, rsp_data_in;
   sulk_pkg::cell_ctl_type            ctl;

   logic signed [sulk_pkg::KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]               less_vec;
   logic [CAPACITY-1:0]               hit_vec;
   logic [CAPACITY-1:0]               bound_vec;
   logic [IDX_W-1:0]                  hit_idx;
   logic [IDX_W-1:0]                  slot_idx;
   logic                              hit_any;
   logic                              is_full;
   logic                              out_free;
   logic [IDX_W-1:0]                  pos_sel;
   logic [IDX_W+sulk_pkg::POS_W-1:0]  pos_ext;
   logic [CNT_W+sulk_pkg::COUNT_W-1:0] cnt_ext;

   // Row of cells, each fed by its left neighbor; the first is fed by the probe key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [sulk_pkg::KEY_W-1:0] left_key;
      logic                              left_less;
      if (i == 0) begin : g_head
         assign left_key  = op_key_ff;
         assign left_less = 1'b1;
      end else begin : g_body
         assign left_key  = cell_key[i-1];
         assign left_less = less_vec[i-1];
      end
      assign bound_vec[i] = left_less & ~less_vec[i];

      sulk_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .probe_key (op_key_ff),
         .key_count (count_ff),
         .left_key  (left_key),
         .left_less (left_less),
         .key_out   (cell_key[i]),
         .less_out  (less_vec[i]),
         .hit_out   (hit_vec[i])
      );
   end

   sulk_encoder #(.N(CAPACITY), .W(IDX_W)) u_hit_enc (
      .onehot (hit_vec),
      .index  (hit_idx)
   );

   sulk_encoder #(.N(CAPACITY), .W(IDX_W)) u_slot_enc (
      .onehot (bound_vec),
      .index  (slot_idx)
   );

   // Sequence one word through compare and resolve
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      ctl            = '0;
      req_ready      = 1'b0;
      hit_any        = |hit_vec;
      is_full        = count_ff == CNT_W'(CAPACITY);
      out_free       = !rsp_valid_ff || rsp_ready;
      pos_sel        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ctl.compare_en = 1'b1;
            state_in       = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (op_cmd_ff == sulk_pkg::CMD_SEARCH) begin
                  if (hit_any) begin
                     rsp_data_in.status = sulk_pkg::STATUS_FOUND;
                     pos_sel            = hit_idx;
                  end else begin
                     rsp_data_in.status = sulk_pkg::STATUS_NOT_FOUND;
                  end
               end else if (hit_any) begin
                  rsp_data_in.status = sulk_pkg::STATUS_DUPLICATE;
                  pos_sel            = hit_idx;
               end else if (is_full) begin
                  rsp_data_in.status = sulk_pkg::STATUS_FULL;
               end else begin
                  rsp_data_in.status = sulk_pkg::STATUS_INSERTED;
                  pos_sel            = slot_idx;
                  ctl.insert_en      = 1'b1;
                  count_in           = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Mask position and count to the word field widths
      pos_ext              = {{sulk_pkg::POS_W{1'b0}}, pos_sel};
      cnt_ext              = {{sulk_pkg::COUNT_W{1'b0}}, count_in};
      if (state_ff == ST_RESOLVE && out_free) begin
         rsp_data_in.position = pos_ext[sulk_pkg::POS_W-1:0];
         rsp_data_in.count    = cnt_ext[sulk_pkg::COUNT_W-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted word and the pending result
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_cmd_ff <= req_data.cmd;
         op_key_ff <= req_data.key;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count above capacity");

   a_hit_unique : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESOLVE |-> $onehot0(hit_vec))
      else $error("key held in more than one cell");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      ctl.insert_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance the count");

   a_insert_slot : assert property (@(posedge clock) disable iff (reset)
      ctl.insert_en |-> $onehot(bound_vec))
      else $error("insert without a single slot boundary");
`endif

endmodule

// File: sv/sulk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sulk_cell
// One slot of the sorted list: holds a key, compares it with the probe key
// and takes either the probe or its left neighbor's key on an insert.
// ----------------------------------------------------------------------------
module sulk_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                              clock,
   input  sulk_pkg::cell_ctl_type            ctl,
   input  logic signed [sulk_pkg::KEY_W-1:0] probe_key,
   input  logic [CNT_W-1:0]                  key_count,
   input  logic signed [sulk_pkg::KEY_W-1:0] left_key,
   input  logic                              left_less,
   output logic signed [sulk_pkg::KEY_W-1:0] key_out,
   output logic                              less_out,
   output logic                              hit_out
);

   logic signed [sulk_pkg::KEY_W-1:0] key_ff;
   logic                              less_ff;
   logic                              less_in;
   logic                              hit_ff;
   logic                              hit_in;
   logic                              occupied;

   // Compare the held key against the probe; empty slots never match
   always_comb begin
      occupied = key_count > CNT_W'(INDEX);
      less_in  = occupied && (key_ff < probe_key);
      hit_in   = occupied && (key_ff == probe_key);
   end

   // Capture flags, then on insert shift right of the slot or drop the probe in
   always_ff @(posedge clock) begin
      if (ctl.compare_en) begin
         less_ff <= less_in;
         hit_ff  <= hit_in;
      end
      if (ctl.insert_en) begin
         if (!left_less) begin
            key_ff <= left_key;
         end else if (!less_ff) begin
            key_ff <= probe_key;
         end
      end
   end

   assign key_out  = key_ff;
   assign less_out = less_ff;
   assign hit_out  = hit_ff;

endmodule

// File: sv/sulk_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sulk_encoder
// One-hot to binary index encoder over the cell flag row.
// ----------------------------------------------------------------------------
module sulk_encoder #(
   parameter int N = 64,
   parameter int W = 6
) (
   input  logic [N-1:0] onehot,
   output logic [W-1:0] index
);

   // OR together the indexes of the set bits
   always_comb begin
      index = '0;
      for (int i = 0; i < N; i++) begin
         if (onehot[i]) begin
            index = index | W'(i);
         end
      end
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted unique key list. A scoreboard keeps its
// own ascending copy of the held keys and predicts status, position and count
// for every accepted request word. Each response word is then compared with
// the oldest prediction, field by field. The stimulus is a short directed run
// followed by random insert and search words: held keys, neighbors of held
// keys, boundary keys and wide random keys. It runs under three idling
// patterns and one long response hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_WORDS = 1500;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   // Model of the key list: predicts one response word per request word
   class key_list_scoreboard;
      logic signed [sulk_pkg::KEY_W-1:0] held_keys[$];
      sulk_pkg::rsp_type                 pending_rsp[$];
      int                                mismatches;

      task report_mismatch(input string what);
         mismatches++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      function void note_request(input sulk_pkg::req_type w);
         logic signed [sulk_pkg::KEY_W-1:0] k;
         sulk_pkg::rsp_type                 r;
         int                                at;
         int                                slot;
         k  = w.key;
         r  = '0;
         at = -1;
         foreach (held_keys[i]) begin
            if (held_keys[i] == k) at = i;
         end
         if (w.cmd == sulk_pkg::CMD_SEARCH) begin
            if (at >= 0) begin
               r.status   = sulk_pkg::STATUS_FOUND;
               r.position = sulk_pkg::POS_W'(at);
            end else begin
               r.status = sulk_pkg::STATUS_NOT_FOUND;
            end
         end else if (at >= 0) begin
            // duplicate wins over full
            r.status   = sulk_pkg::STATUS_DUPLICATE;
            r.position = sulk_pkg::POS_W'(at);
         end else if (held_keys.size() >= LIST_DEPTH) begin
            r.status = sulk_pkg::STATUS_FULL;
         end else begin
            // place the key ahead of the first larger one
            slot = 0;
            while (slot < held_keys.size() && held_keys[slot] < k) slot++;
            held_keys.insert(slot, k);
            r.status   = sulk_pkg::STATUS_INSERTED;
            r.position = sulk_pkg::POS_W'(slot);
         end
         r.count = sulk_pkg::COUNT_W'(held_keys.size());
         pending_rsp.push_back(r);
      endfunction

      task check_response(input sulk_pkg::rsp_type got);
         sulk_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("response word with none pending: %p", got));
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      got.position, want.position));
         if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sulk_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sulk_pkg::rsp_type rsp_data;

   key_list_scoreboard board = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent    = 0;
   int hold_at       = 32'h7fffffff;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int cycles        = 0;

   // Empty list, both ends of the key range, middle and duplicate inserts,
   // search hits and misses, alternating bit patterns
   sulk_pkg::req_type directed_words [16] = '{
      '{sulk_pkg::CMD_SEARCH, 32'h0000_0000},
      '{sulk_pkg::CMD_INSERT, 32'h0000_0000},
      '{sulk_pkg::CMD_INSERT, 32'h7fff_ffff},
      '{sulk_pkg::CMD_INSERT, 32'h8000_0000},
      '{sulk_pkg::CMD_INSERT, 32'hffff_ffff},
      '{sulk_pkg::CMD_INSERT, 32'h0000_0001},
      '{sulk_pkg::CMD_INSERT, 32'h0000_0000},
      '{sulk_pkg::CMD_INSERT, 32'h8000_0000},
      '{sulk_pkg::CMD_SEARCH, 32'h7fff_ffff},
      '{sulk_pkg::CMD_SEARCH, 32'hffff_ffff},
      '{sulk_pkg::CMD_SEARCH, 32'h0000_0002},
      '{sulk_pkg::CMD_SEARCH, 32'h8000_0001},
      '{sulk_pkg::CMD_INSERT, 32'h5555_5555},
      '{sulk_pkg::CMD_INSERT, 32'haaaa_aaaa},
      '{sulk_pkg::CMD_SEARCH, 32'h5555_5555},
      '{sulk_pkg::CMD_SEARCH, 32'haaaa_aaaa}
   };

   sorted_unique_key_list #(.CAPACITY(LIST_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Draw a random request word: held keys, close misses, small, boundary or wide keys
   function automatic sulk_pkg::req_type make_word();
      sulk_pkg::req_type w;
      int                pick;
      int                held;
      w.cmd = ($urandom_range(99) < 55) ? sulk_pkg::CMD_INSERT : sulk_pkg::CMD_SEARCH;
      pick  = $urandom_range(99);
      held  = board.held_keys.size();
      if (held > 0 && pick < 40) begin
         w.key = board.held_keys[$urandom_range(held - 1)];
      end else if (held > 0 && pick < 50) begin
         w.key = board.held_keys[$urandom_range(held - 1)] +
                 (($urandom_range(1) == 0) ? -1 : 1);
      end else if (pick < 62) begin
         w.key = int'($urandom_range(40)) - 20;
      end else if (pick < 70) begin
         w.key = ($urandom_range(1) == 0) ? 32'h8000_0000 + $urandom_range(3)
                                          : 32'h7fff_ffff - $urandom_range(3);
      end else begin
         w.key = $urandom;
      end
      return w;
   endfunction

   // Offer one word after a random gap and hold it until taken
   task automatic issue_word(input sulk_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(w);
      words_sent++;
   endtask

   // Response side: check taken words, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && words_sent >= hold_at) begin
            // long hold-off: the block must fill and stall its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 14;
      recv_idle_pct = 56;
      foreach (directed_words[i]) issue_word(directed_words[i]);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 14;
         end
         if (n == 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_at       = words_sent + 20;
         end
         issue_word(make_word());
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then let the pipeline settle
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
